// File: src/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and codes for the min priority queue: beat structs, status
// and operation codes, and the control and result groups of the scan unit.
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int PRIO_W   = 8;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    // input beat
    typedef struct packed {
        logic                     func;
        logic [PRIO_W-1:0]        priority_req;
        logic signed [DATA_W-1:0] payload;
    } t_in;

    // result beat
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [PRIO_W-1:0]        out_priority;
        logic signed [DATA_W-1:0] out_payload;
    } t_out;

    // sequencer to scan unit
    typedef struct packed {
        logic clear;
        logic cand_vld;
    } t_scan_ctl;

    // best entry seen so far
    typedef struct packed {
        logic              found;
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } t_best;

endpackage

// File: src/mpq_ram.sv
// ----------------------------------------------------------------------------
// mpq_ram
// Generic simple dual port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module mpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/mpq_min_unit.sv
// ----------------------------------------------------------------------------
// mpq_min_unit
// Shared compare unit: takes one candidate entry per cycle and keeps the
// one with the smallest priority, the earliest candidate winning ties.
// ----------------------------------------------------------------------------
module mpq_min_unit #(
    parameter int IDX_W = 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mpq_pkg::t_scan_ctl        i_ctl,
    input  logic [mpq_pkg::PRIO_W-1:0] i_cand_prio,
    input  logic [mpq_pkg::DATA_W-1:0] i_cand_data,
    input  logic [IDX_W-1:0]          i_cand_idx,
    output mpq_pkg::t_best            o_best,
    output logic [IDX_W-1:0]          o_best_idx
);
    import mpq_pkg::*;

    logic              r_found;
    logic [PRIO_W-1:0] r_prio;
    logic [DATA_W-1:0] r_data;
    logic [IDX_W-1:0]  r_idx;
    logic              take;

    // strict less-than keeps the lower slot on a tie
    assign take = i_ctl.cand_vld && (!r_found || (i_cand_prio < r_prio));

    // found flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    // best entry payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_prio <= i_cand_prio;
            r_data <= i_cand_data;
            r_idx  <= i_cand_idx;
        end
    end

    assign o_best.found = r_found;
    assign o_best.prio  = r_prio;
    assign o_best.data  = r_data;
    assign o_best_idx   = r_idx;

endmodule

// File: src/min_priority_queue.sv
// sequence: enqueue scans upward from slot 0 to the lowest free slot;
// overflow and underflow go straight to the done state; dequeue scans
// every slot. One item is in flight at a time: a new beat is taken only
// once the last result beat is loaded, and the slot scan through the
// priority RAM read port and the shared compare unit sets the pace.
// reset: synchronous active-low reset empties the queue (valid bits and
// count cleared); the entry RAMs are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// min_priority_queue
// Small (priority, payload) queue: enqueue fills the lowest free slot,
// dequeue removes the smallest priority found by a sequential slot scan.
// ----------------------------------------------------------------------------
module min_priority_queue #(
    parameter int DEPTH = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mpq_pkg::t_in   i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output mpq_pkg::t_out  o_out
);
    import mpq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ENQ_SCAN = 3'd1;
    localparam logic [2:0] S_DEQ_SCAN = 3'd2;
    localparam logic [2:0] S_DEQ_FIN  = 3'd3;
    localparam logic [2:0] S_DONE     = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_issuing, n_issuing;
    logic              r_cmp_vld, n_cmp_vld;
    logic              r_cmp_live, n_cmp_live;
    logic              r_cmp_last, n_cmp_last;
    logic [IDX_W-1:0]  r_cmp_idx, n_cmp_idx;
    logic [DEPTH-1:0]  r_valid, n_valid;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [PRIO_W-1:0] r_prio, n_prio;
    logic [DATA_W-1:0] r_data, n_data;
    t_out              r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;

    logic              ram_we;
    logic [PRIO_W-1:0] prio_rdata;
    logic [DATA_W-1:0] data_rdata;
    t_scan_ctl         scan_ctl;
    t_best             best;
    logic [IDX_W-1:0]  best_idx;
    logic              in_beat;
    logic              out_free;

    assign in_beat  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // entry write happens at the first free slot of the enqueue scan
    assign ram_we = (r_state == S_ENQ_SCAN) && !r_valid[r_idx];

    // entry stores
    mpq_ram #(
        .WIDTH (PRIO_W),
        .DEPTH (DEPTH)
    ) u_prio_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_prio),
        .i_raddr (r_idx),
        .o_rdata (prio_rdata)
    );

    mpq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_data),
        .i_raddr (r_idx),
        .o_rdata (data_rdata)
    );

    // shared compare unit sees one read-back slot per cycle
    assign scan_ctl.clear    = in_beat;
    assign scan_ctl.cand_vld = r_cmp_vld && r_cmp_live;

    mpq_min_unit #(
        .IDX_W (IDX_W)
    ) u_min_unit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_cand_prio (prio_rdata),
        .i_cand_data (data_rdata),
        .i_cand_idx  (r_cmp_idx),
        .o_best      (best),
        .o_best_idx  (best_idx)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_issuing   = r_issuing;
        n_cmp_vld   = 1'b0;
        n_cmp_live  = r_cmp_live;
        n_cmp_last  = r_cmp_last;
        n_cmp_idx   = r_cmp_idx;
        n_valid     = r_valid;
        n_count     = r_count;
        n_prio      = r_prio;
        n_data      = r_data;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        // output register drains independently
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_prio = i_in.priority_req;
                    n_data = i_in.payload;
                    n_idx  = '0;
                    if (i_in.func == FUNC_ENQ) begin
                        if (r_count == FULL_CNT) begin
                            n_res   = '{ST_OVERFLOW, '0, '0};
                            n_state = S_DONE;
                        end else begin
                            n_state = S_ENQ_SCAN;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res   = '{ST_UNDERFLOW, '0, '0};
                            n_state = S_DONE;
                        end else begin
                            n_issuing = 1'b1;
                            n_state   = S_DEQ_SCAN;
                        end
                    end
                end
            end
            S_ENQ_SCAN: begin
                if (!r_valid[r_idx]) begin
                    n_valid[r_idx] = 1'b1;
                    n_count        = r_count + 1'b1;
                    n_res          = '{ST_OK, '0, '0};
                    n_state        = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DEQ_SCAN: begin
                // issue side: one slot read per cycle
                if (r_issuing) begin
                    n_cmp_vld  = 1'b1;
                    n_cmp_live = r_valid[r_idx];
                    n_cmp_idx  = r_idx;
                    n_cmp_last = (r_idx == LAST_IDX);
                    if (r_idx == LAST_IDX) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                // compare side: last slot is being taken in this cycle
                if (r_cmp_vld && r_cmp_last) begin
                    n_state = S_DEQ_FIN;
                end
            end
            S_DEQ_FIN: begin
                n_valid[best_idx] = 1'b0;
                n_count           = r_count - 1'b1;
                n_res             = '{ST_OK, best.prio, best.data};
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issuing   <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issuing   <= n_issuing;
            r_cmp_vld   <= n_cmp_vld;
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_cmp_live <= n_cmp_live;
        r_cmp_last <= n_cmp_last;
        r_cmp_idx  <= n_cmp_idx;
        r_prio     <= n_prio;
        r_data     <= n_data;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // count tracks the live slots
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(r_valid)))
        else $error("entry count differs from live slot count");

    // count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above depth");

    // enqueue scan only runs while a free slot exists
    a_enq_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ENQ_SCAN) |-> !(&r_valid))
        else $error("enqueue scan with no free slot");

    // a finished dequeue scan has found a live entry
    a_deq_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEQ_FIN) |-> (best.found && r_valid[best_idx]))
        else $error("dequeue scan ended without a live entry");

    // a result beat is loaded only from the done state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result beat raised outside done state");

endmodule

// File: dv/tb_min_priority_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_min_priority_queue
// Self-checking bench for the min priority queue. A table of directed beats
// covers empty and full queues, extreme priorities and payloads, ties and
// slot reuse. Random beats follow, in phases that push the queue toward
// full, toward empty or keep it balanced. Random idle bursts occur on both
// sides. Every result beat is checked against its table entry or a behavioral model of the queue.
// ----------------------------------------------------------------------------
module tb_min_priority_queue;
    import mpq_pkg::*;

    localparam int QDEPTH    = 8;
    localparam int DIR_N     = 21;
    localparam int RAND_N    = 900;
    localparam int CALM_N    = 100;
    localparam int CYCLE_CAP = 400000;

    typedef struct {
        t_in  beat;
        bit   known;
        t_out res;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out;

    // model of the queue contents
    logic [PRIO_W-1:0] mdl_prio [QDEPTH];
    logic [DATA_W-1:0] mdl_data [QDEPTH];
    bit                mdl_live [QDEPTH];
    int                mdl_count;

    t_out     due_results [$];
    t_out     want;
    t_dir_row dir_tab [DIR_N];
    int       mismatches;
    int       cycles;
    int       src_odds;
    int       sink_odds;
    int       sink_stall;

    min_priority_queue #(.DEPTH(QDEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // apply one beat to the model and return the result it causes
    function automatic t_out serve_item(input t_in beat);
        t_out res;
        int   slot;
        res = '0;
        res.status = ST_OK;
        if (beat.func == FUNC_ENQ) begin
            // lowest free slot
            slot = -1;
            for (int i = QDEPTH - 1; i >= 0; i--) begin
                if (!mdl_live[i]) slot = i;
            end
            if (slot < 0 || mdl_count >= QDEPTH) begin
                res.status = ST_OVERFLOW;
            end else begin
                mdl_prio[slot] = beat.priority_req;
                mdl_data[slot] = beat.payload;
                mdl_live[slot] = 1'b1;
                mdl_count++;
            end
        end else begin
            // smallest priority, ties to the lowest slot
            slot = -1;
            for (int i = 0; i < QDEPTH; i++) begin
                if (mdl_live[i] && (slot < 0 || mdl_prio[i] < mdl_prio[slot])) slot = i;
            end
            if (slot < 0) begin
                res.status = ST_UNDERFLOW;
            end else begin
                mdl_live[slot] = 1'b0;
                if (mdl_count > 0) mdl_count--;
                res.out_priority = mdl_prio[slot];
                res.out_payload  = mdl_data[slot];
            end
        end
        return res;
    endfunction

    function automatic t_dir_row row(input logic f, input logic [PRIO_W-1:0] p,
                                     input logic [DATA_W-1:0] d, input bit known,
                                     input logic [STATUS_W-1:0] st);
        t_dir_row r;
        r.beat.func         = f;
        r.beat.priority_req = p;
        r.beat.payload      = d;
        r.known             = known;
        r.res               = '0;
        r.res.status        = st;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [DATA_W-1:0] exp_v,
                                        input logic [DATA_W-1:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    // drive one input beat and hold it until accepted
    task automatic push_item(input t_in beat, input bit known, input t_out typed_res);
        t_out res;
        i_in_valid <= 1'b1;
        i_in       <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        res = serve_item(beat);
        due_results.push_back(known ? typed_res : res);
    endtask

    task automatic idle_input(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // result side stalls in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b1;
            sink_stall  <= 0;
        end else if (sink_stall != 0) begin
            i_out_ready <= 1'b0;
            sink_stall  <= sink_stall - 1;
        end else if (sink_odds != 0 && $urandom_range(0, sink_odds) == 0) begin
            i_out_ready <= 1'b0;
            sink_stall  <= $urandom_range(1, 19) - 1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none actual %h", $time, o_out);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                check_field("status", DATA_W'(want.status), DATA_W'(o_out.status));
                check_field("out_priority", DATA_W'(want.out_priority),
                            DATA_W'(o_out.out_priority));
                check_field("out_payload", want.out_payload, o_out.out_payload);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        t_in  beat;
        int   enq_pct;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        mdl_count  = 0;
        src_odds   = 0;
        sink_odds  = 0;
        enq_pct    = 50;

        // directed beats: empty, fill with extremes and ties, overflow,
        // slot reuse, drain back to empty
        dir_tab = '{
            row(FUNC_DEQ, 8'h00, 32'h0000_0000, 1'b1, ST_UNDERFLOW),
            row(FUNC_ENQ, 8'hff, 32'h7fff_ffff, 1'b1, ST_OK),
            row(FUNC_ENQ, 8'h00, 32'h8000_0000, 1'b1, ST_OK),
            row(FUNC_ENQ, 8'h80, 32'h0000_0000, 1'b1, ST_OK),
            row(FUNC_ENQ, 8'h80, 32'hffff_ffff, 1'b1, ST_OK),
            row(FUNC_ENQ, 8'h55, 32'h5555_5555, 1'b1, ST_OK),
            row(FUNC_ENQ, 8'haa, 32'haaaa_aaaa, 1'b1, ST_OK),
            row(FUNC_ENQ, 8'hff, 32'h0000_0001, 1'b1, ST_OK),
            row(FUNC_ENQ, 8'h01, 32'h0000_1234, 1'b1, ST_OK),
            row(FUNC_ENQ, 8'h07, 32'h1111_2222, 1'b1, ST_OVERFLOW),
            row(FUNC_DEQ, 8'hff, 32'hdead_beef, 1'b0, ST_OK),
            row(FUNC_DEQ, 8'h00, 32'hffff_ffff, 1'b0, ST_OK),
            row(FUNC_ENQ, 8'h80, 32'h0000_dead, 1'b1, ST_OK),
            row(FUNC_DEQ, 8'h00, 32'h0000_0000, 1'b0, ST_OK),
            row(FUNC_DEQ, 8'h00, 32'h0000_0000, 1'b0, ST_OK),
            row(FUNC_DEQ, 8'h00, 32'h0000_0000, 1'b0, ST_OK),
            row(FUNC_DEQ, 8'h00, 32'h0000_0000, 1'b0, ST_OK),
            row(FUNC_DEQ, 8'h00, 32'h0000_0000, 1'b0, ST_OK),
            row(FUNC_DEQ, 8'h00, 32'h0000_0000, 1'b0, ST_OK),
            row(FUNC_DEQ, 8'h00, 32'h0000_0000, 1'b0, ST_OK),
            row(FUNC_DEQ, 8'h5a, 32'h0f0f_0f0f, 1'b1, ST_UNDERFLOW)
        };

        // reset
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        for (int k = 0; k < DIR_N; k++) begin
            push_item(dir_tab[k].beat, dir_tab[k].known, dir_tab[k].res);
        end

        // random part in phases of 60 beats, the last CALM_N beats calm with no idle bursts
        for (int k = 0; k < RAND_N; k++) begin
            if (k >= RAND_N - CALM_N) begin
                src_odds  = 0;
                sink_odds = 0;
                if (k == RAND_N - CALM_N) enq_pct = 50;
            end else if (k % 60 == 0) begin
                case ($urandom_range(0, 2))
                    0:       enq_pct = 15;
                    1:       enq_pct = 50;
                    default: enq_pct = 85;
                endcase
                src_odds  = $urandom_range(0, 2) * 4;
                sink_odds = $urandom_range(0, 2) * 3;
            end
            beat.func = ($urandom_range(1, 100) <= enq_pct) ? FUNC_ENQ : FUNC_DEQ;
            // narrow priorities give ties, extremes hit the ends of the range
            case ($urandom_range(0, 3))
                0:       beat.priority_req = PRIO_W'($urandom_range(0, 3));
                1:       beat.priority_req = $urandom_range(0, 1) ? 8'hff : 8'h00;
                default: beat.priority_req = PRIO_W'($urandom_range(0, 255));
            endcase
            beat.payload = $urandom;
            if (src_odds != 0 && $urandom_range(0, src_odds) == 0) begin
                idle_input($urandom_range(1, 19));
            end
            push_item(beat, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        // drain
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (QDEPTH + 8) @(posedge i_clk);

        if (mismatches == 0 && due_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: files.f
src/mpq_pkg.sv
src/mpq_ram.sv
src/mpq_min_unit.sv
src/min_priority_queue.sv
dv/tb_min_priority_queue.sv
